/* rtl/core/dosunx_pkg.sv */
// Shared types, constants and calendar tables for the DOS stamp to Unix seconds converter.
package dosunx_pkg;

   localparam int unsigned DATE_W = 16;
   localparam int unsigned TIME_W = 16;
   localparam int unsigned SECS_W = 33;
   localparam int unsigned DAYS_W = 16;
   localparam int unsigned TOD_W  = 17;

   // Days from 1970-01-01 to 1980-01-01
   localparam logic [DAYS_W-1:0] EPOCH_1980_DAYS = 16'd3652;
   // Year offset of 2100, the only non-leap multiple of four in range
   localparam logic [6:0] YOFF_2100 = 7'd120;

   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_DEC = 4'd12;
   localparam logic [4:0] HOUR_MAX  = 5'd23;
   localparam logic [5:0] MIN_MAX   = 6'd59;
   localparam logic [4:0] SEC2_MAX  = 5'd29;

   typedef struct packed {
      logic [DATE_W-1:0] dos_date;
      logic [TIME_W-1:0] dos_time;
   } req_type;

   typedef struct packed {
      logic              stamp_valid;
      logic [SECS_W-1:0] unix_seconds;
   } rsp_type;

   // Days in a common year before the first of the given month
   function automatic logic [8:0] days_before_month(input logic [3:0] month);
      logic [8:0] d;
      begin
         unique case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
         endcase
         return d;
      end
   endfunction

   // Length of the month in a common year
   function automatic logic [4:0] month_length(input logic [3:0] month);
      logic [4:0] d;
      begin
         unique case (month)
            4'd2:                       d = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    d = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:         d = 5'd31;
            default:                    d = 5'd0;
         endcase
         return d;
      end
   endfunction

endpackage

/* rtl/core/dosunx_convert.sv */
// Combinational conversion of one DOS date/time pair into Unix seconds.
module dosunx_convert (
   input  dosunx_pkg::req_type stamp,
   output dosunx_pkg::rsp_type result
);
   import dosunx_pkg::*;

   logic [6:0]        yoff;
   logic [3:0]        month;
   logic [4:0]        day;
   logic [4:0]        hour;
   logic [5:0]        minute;
   logic [4:0]        sec2;
   logic              leap;
   logic [4:0]        last_day;
   logic              fields_ok;
   logic [DAYS_W-1:0] year_days;
   logic [DAYS_W-1:0] days;
   logic [TOD_W-1:0]  tod_secs;
   logic [SECS_W-1:0] secs;

   // Field split
   assign yoff   = stamp.dos_date[15:9];
   assign month  = stamp.dos_date[8:5];
   assign day    = stamp.dos_date[4:0];
   assign hour   = stamp.dos_time[15:11];
   assign minute = stamp.dos_time[10:5];
   assign sec2   = stamp.dos_time[4:0];

   // Gregorian leap rule over 1980..2107: only 2100 among multiples of four fails
   assign leap = (yoff[1:0] == 2'd0) && (yoff != YOFF_2100);

   // Range checks
   assign last_day  = month_length(month) + 5'((month == MONTH_FEB) && leap);
   assign fields_ok = (month != 4'd0) && (month <= MONTH_DEC) && (hour <= HOUR_MAX)
                   && (minute <= MIN_MAX) && (sec2 <= SEC2_MAX)
                   && (day != 5'd0) && (day <= last_day);

   // Days from 1970 to 1 January of this year; leap years from 1980 on, less 2100
   assign year_days = EPOCH_1980_DAYS + DAYS_W'(yoff) * DAYS_W'(365)
                    + DAYS_W'((8'(yoff) + 8'd3) >> 2) - DAYS_W'(yoff > YOFF_2100);

   // Days since 1970
   assign days = year_days + DAYS_W'(days_before_month(month))
               + DAYS_W'((month > MONTH_FEB) && leap) + DAYS_W'(day) - DAYS_W'(1);

   // Time of day
   assign tod_secs = TOD_W'(hour) * TOD_W'(3600) + TOD_W'(minute) * TOD_W'(60)
                   + TOD_W'({sec2, 1'b0});

   assign secs = SECS_W'(days) * SECS_W'(86400) + SECS_W'(tod_secs);

   assign result.stamp_valid  = fields_ok;
   assign result.unix_seconds = fields_ok ? secs : '0;

endmodule

/* rtl/core/dos_datetime_to_unix_seconds.sv */
// Top level: registered DOS date/time to Unix seconds converter.
// Converts one DOS date/time transaction per cycle. A transaction is captured
// in an input register, converted by one pass of combinational logic (range
// checks, calendar tables and constant multiplies, one by 86400) and held in a
// result register that offers it on rsp, and new transactions are taken every
// cycle while the result side keeps up. The block holds at most two
// transactions; once both registers are full and the result side stalls, the
// input stalls too. Years 1980..2107 are covered; out-of-range stamps give
// stamp_valid 0 and seconds 0.
module dos_datetime_to_unix_seconds (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  dosunx_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output dosunx_pkg::rsp_type rsp_data
);
   import dosunx_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type conv;
   logic    out_move;
   logic    in_take;

   // Handshake control
   assign out_move  = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !out_move;
   assign in_take   = req_valid && !req_stall;

   assign in_valid_in  = in_take || (in_valid_ff && !out_move);
   assign out_valid_in = out_move ? in_valid_ff : out_valid_ff;

   // Conversion
   dosunx_convert u_convert (
      .stamp  (in_data_ff),
      .result (conv)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_data_ff <= req_data;
      end
      if (out_move && in_valid_ff) begin
         out_data_ff <= conv;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Invalid stamps always carry zero seconds
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_data_ff.stamp_valid |-> out_data_ff.unix_seconds == '0)
      else $error("invalid stamp with non-zero seconds");

   // Valid stamps never fall before 1980-01-01
   a_valid_floor: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.stamp_valid |-> out_data_ff.unix_seconds >= 33'd315532800)
      else $error("valid stamp before 1980");

   // Input stage only stalls when it holds a transaction
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("stall with empty input stage");

   // A held input transaction stays in place
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_move |=> in_valid_ff && $stable(in_data_ff))
      else $error("held transaction lost");

endmodule

/* verif/tb_dos_datetime_to_unix_seconds.sv */
// Self-checking testbench for the DOS date/time to Unix seconds converter.
module tb_dos_datetime_to_unix_seconds;
   import dosunx_pkg::*;

   localparam int unsigned IDLE_PCT   = 8;
   localparam int unsigned HOLD_LEN   = 80;
   localparam int unsigned SETTLE_CYC = 8;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Shared between the test sequence and the result monitor
   rsp_type     expected_stamps[$];
   int unsigned mismatches = 0;
   bit          quiet      = 1'b0;
   int unsigned hold_seq   = 0;

   dos_datetime_to_unix_seconds dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Month length with the Gregorian leap rule; 0 for a month out of range
   function automatic int unsigned cal_month_len(input int unsigned year,
                                                 input int unsigned month);
      bit leap;
      leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
      case (month)
         2:                       return leap ? 29 : 28;
         4, 6, 9, 11:             return 30;
         1, 3, 5, 7, 8, 10, 12:   return 31;
         default:                 return 0;
      endcase
   endfunction

   // Expected conversion: range checks, then days from a March-based year
   function automatic rsp_type convert_stamp(input req_type stamp);
      int unsigned year, month, day, hour, minute, second;
      int unsigned march_year, era, yr_in_era, month_idx, day_in_year, day_in_era;
      longint unsigned days;
      rsp_type conv;
      year   = 1980 + stamp.dos_date[15:9];
      month  = stamp.dos_date[8:5];
      day    = stamp.dos_date[4:0];
      hour   = stamp.dos_time[15:11];
      minute = stamp.dos_time[10:5];
      second = stamp.dos_time[4:0] * 2;
      conv   = '0;
      if (month < 1 || month > 12 || hour > 23 || minute > 59 || second > 59)
         return conv;
      if (day < 1 || day > cal_month_len(year, month))
         return conv;
      march_year  = (month <= 2) ? year - 1 : year;
      era         = march_year / 400;
      yr_in_era   = march_year - era * 400;
      month_idx   = (month > 2) ? month - 3 : month + 9;
      day_in_year = (153 * month_idx + 2) / 5 + day - 1;
      day_in_era  = yr_in_era * 365 + yr_in_era / 4 - yr_in_era / 100 + day_in_year;
      days        = 64'(era) * 146097 + 64'(day_in_era) - 719468;
      conv.stamp_valid  = 1'b1;
      conv.unix_seconds = SECS_W'(days * 86400 + 64'(hour * 3600 + minute * 60 + second));
      return conv;
   endfunction

   function automatic logic [DATE_W-1:0] make_date(input int unsigned yoff,
                                                   input int unsigned month,
                                                   input int unsigned day);
      return {yoff[6:0], month[3:0], day[4:0]};
   endfunction

   function automatic logic [TIME_W-1:0] make_time(input int unsigned hour,
                                                   input int unsigned minute,
                                                   input int unsigned sec2);
      return {hour[4:0], minute[5:0], sec2[4:0]};
   endfunction

   // Offer one transaction and hold it until accepted; valid stays high afterwards
   task automatic send_stamp(input logic [DATE_W-1:0] date, input logic [TIME_W-1:0] tod);
      req_type stamp;
      stamp = '{dos_date: date, dos_time: tod};
      if (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= stamp;
      do @(posedge clock); while (req_stall);
      expected_stamps.push_back(convert_stamp(stamp));
   endtask

   // Mostly well-formed stamps with random content; the rest broken or raw noise
   task automatic send_random_stamp(input int unsigned valid_pct);
      int unsigned yoff, month, day, len;
      logic [DATE_W-1:0] date;
      logic [TIME_W-1:0] tod;
      yoff  = $urandom_range(127);
      month = $urandom_range(1, 12);
      len   = cal_month_len(1980 + yoff, month);
      day   = $urandom_range(1, len);
      tod   = make_time($urandom_range(23), $urandom_range(59), $urandom_range(29));
      if ($urandom_range(99) >= valid_pct) begin
         case ($urandom_range(2))
            0: begin
               tod  = TIME_W'($urandom);
               date = DATE_W'($urandom);
               send_stamp(date, tod);
               return;
            end
            1:       day = (len < 31) ? $urandom_range(len + 1, 31) : 0;
            default: tod[15:11] = 5'($urandom_range(24, 31));
         endcase
      end
      send_stamp(make_date(yoff, month, day), tod);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_stamps.size() != 0) @(posedge clock);
   endtask

   // Calendar and clock extremes, leap rules and every kind of bad field
   task automatic test_directed();
      send_stamp(make_date(0, 1, 1), make_time(0, 0, 0));
      send_stamp(make_date(127, 12, 31), make_time(23, 59, 29));
      send_stamp(make_date(127, 1, 1), make_time(0, 0, 0));
      send_stamp(make_date(20, 2, 29), make_time(12, 30, 15));
      send_stamp(make_date(120, 2, 29), make_time(1, 2, 3));
      send_stamp(make_date(120, 2, 28), make_time(23, 59, 29));
      send_stamp(make_date(120, 3, 1), make_time(0, 0, 0));
      send_stamp(make_date(1, 2, 29), make_time(6, 0, 0));
      send_stamp(make_date(0, 2, 29), make_time(6, 0, 0));
      send_stamp(make_date(19, 12, 31), make_time(23, 59, 29));
      send_stamp(make_date(44, 6, 30), make_time(8, 15, 10));
      send_stamp(make_date(10, 6, 0), make_time(8, 0, 0));
      send_stamp(make_date(10, 4, 31), make_time(8, 0, 0));
      send_stamp(make_date(10, 1, 31), make_time(8, 0, 0));
      send_stamp(make_date(5, 0, 10), make_time(8, 0, 0));
      send_stamp(make_date(5, 13, 10), make_time(8, 0, 0));
      send_stamp(16'hffff, 16'h0000);
      send_stamp(16'h0000, 16'h0000);
      send_stamp(make_date(30, 7, 4), 16'hffff);
      send_stamp(make_date(30, 7, 4), make_time(24, 0, 0));
      send_stamp(make_date(30, 7, 4), make_time(31, 0, 0));
      send_stamp(make_date(30, 7, 4), make_time(10, 60, 0));
      send_stamp(make_date(30, 7, 4), make_time(10, 63, 0));
      send_stamp(make_date(30, 7, 4), make_time(10, 0, 30));
      send_stamp(make_date(30, 7, 4), make_time(10, 0, 31));
   endtask

   task automatic test_random_mixed(input int unsigned count);
      repeat (count) send_random_stamp(75);
   endtask

   // Back-to-back transactions with neither side idling
   task automatic test_full_rate();
      quiet = 1'b1;
      repeat (150) send_random_stamp(90);
      quiet = 1'b0;
   endtask

   // Receiver holds off while the sender keeps offering, so the input stalls
   task automatic test_backpressure();
      quiet    = 1'b1;
      hold_seq = hold_seq + 1;
      repeat (24) send_random_stamp(80);
      quiet    = 1'b0;
   endtask

   // Sender stops until every outstanding result is back, then resumes
   task automatic test_drain_pause();
      repeat (20) send_random_stamp(80);
      wait_for_drain();
      repeat (20) send_random_stamp(80);
   endtask

   // Result monitor: compare each accepted transaction, then drive stall for the next edge
   initial begin
      rsp_type     want;
      int unsigned hold_left;
      int unsigned hold_seen;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_stamps.size() == 0) begin
               $error("unexpected result: stamp_valid %0d unix_seconds %0d",
                      rsp_data.stamp_valid, rsp_data.unix_seconds);
               mismatches++;
            end else begin
               want = expected_stamps.pop_front();
               if (rsp_data.stamp_valid !== want.stamp_valid) begin
                  $error("stamp_valid: expected %0d, actual %0d",
                         want.stamp_valid, rsp_data.stamp_valid);
                  mismatches++;
               end
               if (rsp_data.unix_seconds !== want.unix_seconds) begin
                  $error("unix_seconds: expected %0d, actual %0d",
                         want.unix_seconds, rsp_data.unix_seconds);
                  mismatches++;
               end
            end
         end
         if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // Test sequence
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_mixed(300);
      test_full_rate();
      test_backpressure();
      test_drain_pause();
      test_random_mixed(230);
      wait_for_drain();
      repeat (SETTLE_CYC) @(posedge clock);
      if (mismatches == 0 && expected_stamps.size() == 0) begin
         $display("dos_datetime_to_unix_seconds: match");
      end else begin
         $display("dos_datetime_to_unix_seconds: mismatch");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #200000;
      $display("dos_datetime_to_unix_seconds: mismatch");
      $finish;
   end

endmodule

/* dos_datetime_to_unix_seconds.f */
rtl/core/dosunx_pkg.sv
rtl/core/dosunx_convert.sv
rtl/core/dos_datetime_to_unix_seconds.sv
verif/tb_dos_datetime_to_unix_seconds.sv
